@@ rtl/ffa_pkg.sv @@
// Package: shared types and constants for the first-fit aligned allocator.
package ffa_pkg;
    localparam int unsigned MaxChunks = 64;
    localparam int unsigned AddrBits  = 32;
    localparam int unsigned IdxBits   = $clog2(MaxChunks);
    localparam int unsigned CntBits   = $clog2(MaxChunks + 1);
    localparam logic [31:0] PoolReset = 32'd65536;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOT_FND  = 2'd3
    } t_status;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] alloc_size;
        logic [4:0]  align_log2;
        logic [31:0] free_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_offset;
        logic [31:0] result_size;
    } t_rsp;

    typedef struct packed {
        logic [AddrBits-1:0] start;
        logic [AddrBits-1:0] len;
        logic                busy;
    } t_entry;
endpackage

@@ rtl/first_fit_aligned_allocator.sv @@
// Top level: chunk table memory and request sequencer of the allocator.
//
//  channel | signals                              | dir | handshake
//  request | i_start, o_busy, i_req               | in  | start & !busy
//  result  | o_done, o_rsp                        | out | one-cycle strobe
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_data | in  | valid & ready
//
// Allocate: scans entries (read, check), moves entries up (read, write), then writes the new entries.
// Free: scans entries (read, find), merges with free neighbours, then moves entries down (read, write).
// Scans and moves share the table's one read port and one write port.
// After reset and each pool write, entry 0 is rebuilt while busy is high.
// The result strobe cannot be stalled; a new request may be taken in the strobe cycle.
module first_fit_aligned_allocator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  ffa_pkg::t_req    i_req,
    output logic             o_done,
    output ffa_pkg::t_rsp    o_rsp,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [31:0]      i_cfg_data
);
    import ffa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CHK, S_FND, S_NXT, S_MWR,
        S_SHR, S_SHW, S_WR, S_DONE
    } t_state;

    t_entry              mem [MaxChunks];
    t_entry              r_rd;
    t_state              r_st;
    t_req                r_req;
    logic [CntBits-1:0]  r_live;
    logic [CntBits-1:0]  r_i;
    logic [CntBits-1:0]  r_k;
    logic [AddrBits-1:0] r_pad, r_rest, r_st0;
    t_entry              r_cur;
    t_entry              r_pv;
    logic                r_prv_free;
    logic [1:0]          r_dn;
    logic [1:0]          r_wcnt;
    logic                r_del;
    t_rsp                r_rsp;
    logic                r_done;
    logic [AddrBits-1:0] r_cfg_pool;
    logic                r_init;

    logic                we;
    logic [IdxBits-1:0]  wa, ra;
    t_entry              wd, alloc_wd;
    logic [AddrBits-1:0] amask, pad_c, avail, rest_c;
    logic [1:0]          need_c;
    logic                fit, full, nxt_free;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[ra];
    end

    assign amask    = (AddrBits'(1) << r_req.align_log2) - AddrBits'(1);
    assign pad_c    = (AddrBits'(0) - r_rd.start) & amask;
    assign avail    = r_rd.len - pad_c;
    assign rest_c   = avail - r_req.alloc_size;
    assign fit      = !r_rd.busy && (pad_c <= r_rd.len) && (r_req.alloc_size <= avail);
    assign need_c   = {1'b0, pad_c != '0} + {1'b0, rest_c != '0};
    assign full     = ({1'b0, r_live} + (CntBits+1)'(need_c)) > (CntBits+1)'(MaxChunks);
    assign nxt_free = (r_i + CntBits'(1) < r_live) && !r_rd.busy;

    assign o_busy      = (r_st != S_IDLE) || r_init;
    assign o_cfg_ready = (r_st == S_IDLE) && !r_init && !i_start;
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;

    // Entries written after an allocate split: left pad, request, right rest.
    always_comb begin
        alloc_wd = '{start: r_st0 + r_pad, len: r_req.alloc_size, busy: 1'b1};
        unique case (r_wcnt)
            2'd0: begin
                if (r_pad != '0) begin
                    alloc_wd = '{start: r_st0, len: r_pad, busy: 1'b0};
                end else begin
                    alloc_wd = '{start: r_st0, len: r_req.alloc_size, busy: 1'b1};
                end
            end
            2'd1: begin
                if (r_pad == '0) begin
                    alloc_wd = '{start: r_st0 + r_req.alloc_size, len: r_rest, busy: 1'b0};
                end
            end
            default: begin
                alloc_wd = '{start: r_st0 + r_pad + r_req.alloc_size, len: r_rest,
                             busy: 1'b0};
            end
        endcase
    end

    // Table port control, combinational from state.
    always_comb begin
        we = 1'b0;
        wa = r_i[IdxBits-1:0];
        wd = r_cur;
        ra = r_i[IdxBits-1:0];
        unique case (r_st)
            S_IDLE: begin
                we = r_init;
                wa = '0;
                wd = '{start: '0, len: r_cfg_pool, busy: 1'b0};
            end
            S_FND:   ra = IdxBits'(r_i + CntBits'(1));
            S_SHR:   ra = r_k[IdxBits-1:0];
            S_SHW: begin
                we = 1'b1;
                wd = r_rd;
                wa = r_del ? IdxBits'(r_k - CntBits'(r_dn)) : IdxBits'(r_k + CntBits'(r_dn));
            end
            S_WR: begin
                we = 1'b1;
                wa = IdxBits'(r_i + CntBits'(r_wcnt));
                wd = alloc_wd;
            end
            S_MWR: begin
                we = 1'b1;
                wa = r_k[IdxBits-1:0];
                wd = r_cur;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= S_IDLE;
            r_live     <= CntBits'(1);
            r_done     <= 1'b0;
            r_init     <= 1'b1;
            r_cfg_pool <= PoolReset;
        end else begin
            r_done <= 1'b0;
            r_init <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (r_init) begin
                        r_live <= CntBits'(1);
                    end else if (i_start) begin
                        r_req      <= i_req;
                        r_i        <= '0;
                        r_prv_free <= 1'b0;
                        r_rsp      <= '0;
                        if (i_req.req_type == REQ_ALLOC && i_req.alloc_size == '0) begin
                            r_rsp.status <= ST_NO_FIT;
                            r_st <= S_DONE;
                        end else begin
                            r_st <= S_RD;
                        end
                    end else if (i_cfg_valid) begin
                        r_cfg_pool <= i_cfg_data;
                        r_init     <= 1'b1;
                    end
                end
                S_RD: begin
                    if (r_i >= r_live) begin
                        r_rsp.status <= (r_req.req_type == REQ_FREE) ? ST_NOT_FND : ST_NO_FIT;
                        r_st <= S_DONE;
                    end else begin
                        r_st <= (r_req.req_type == REQ_FREE) ? S_FND : S_CHK;
                    end
                end
                S_CHK: begin
                    if (fit) begin
                        if (full) begin
                            r_rsp.status <= ST_FULL;
                            r_st <= S_DONE;
                        end else begin
                            r_rsp.status        <= ST_OK;
                            r_rsp.result_offset <= r_rd.start + pad_c;
                            r_rsp.result_size   <= r_req.alloc_size;
                            r_pad  <= pad_c;
                            r_rest <= rest_c;
                            r_st0  <= r_rd.start;
                            r_dn   <= need_c;
                            r_del  <= 1'b0;
                            r_wcnt <= '0;
                            r_k    <= r_live - CntBits'(1);
                            if (need_c != '0 && r_i + CntBits'(1) < r_live) begin
                                r_st <= S_SHR;
                            end else begin
                                r_st <= S_WR;
                            end
                        end
                    end else begin
                        r_i  <= r_i + CntBits'(1);
                        r_st <= S_RD;
                    end
                end
                S_FND: begin
                    if (r_rd.busy && r_rd.start == r_req.free_offset) begin
                        r_cur <= r_rd;
                        r_rsp.status        <= ST_OK;
                        r_rsp.result_offset <= r_rd.start;
                        r_rsp.result_size   <= r_rd.len;
                        r_st <= S_NXT;
                    end else begin
                        r_pv       <= r_rd;
                        r_prv_free <= !r_rd.busy;
                        r_i  <= r_i + CntBits'(1);
                        r_st <= S_RD;
                    end
                end
                S_NXT: begin
                    r_cur <= '{start: r_prv_free ? r_pv.start : r_cur.start,
                               len: r_cur.len + (nxt_free ? r_rd.len : '0)
                                    + (r_prv_free ? r_pv.len : '0),
                               busy: 1'b0};
                    r_k   <= r_prv_free ? r_i - CntBits'(1) : r_i;
                    r_dn  <= {1'b0, r_prv_free} + {1'b0, nxt_free};
                    r_del <= 1'b1;
                    r_st  <= S_MWR;
                end
                S_MWR: begin
                    if (r_dn != '0 && (r_k + CntBits'(1) + CntBits'(r_dn) < r_live)) begin
                        r_k  <= r_k + CntBits'(1) + CntBits'(r_dn);
                        r_st <= S_SHR;
                    end else begin
                        r_live <= r_live - CntBits'(r_dn);
                        r_st   <= S_DONE;
                    end
                end
                S_SHR: r_st <= S_SHW;
                S_SHW: begin
                    if (!r_del) begin
                        if (r_k == r_i + CntBits'(1)) begin
                            r_st <= S_WR;
                        end else begin
                            r_k  <= r_k - CntBits'(1);
                            r_st <= S_SHR;
                        end
                    end else begin
                        if (r_k + CntBits'(1) >= r_live) begin
                            r_live <= r_live - CntBits'(r_dn);
                            r_st   <= S_DONE;
                        end else begin
                            r_k  <= r_k + CntBits'(1);
                            r_st <= S_SHR;
                        end
                    end
                end
                S_WR: begin
                    if (r_wcnt == r_dn) begin
                        r_live <= r_live + CntBits'(r_dn);
                        r_st   <= S_DONE;
                    end else begin
                        r_wcnt <= r_wcnt + 2'd1;
                    end
                end
                S_DONE: begin
                    r_done <= 1'b1;
                    r_st   <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/ffa_checker.sv @@
// Checker: port-level properties of the allocator, bound to the top level.
module ffa_props (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input logic          o_busy,
    input logic          o_done,
    input ffa_pkg::t_rsp o_rsp,
    input logic          o_cfg_ready
);
    import ffa_pkg::*;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy)) else $error("result without request");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("request not taken");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != ST_OK) |-> (o_rsp.result_offset == '0
        && o_rsp.result_size == '0)) else $error("error result not zero");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_busy) else $error("config while busy");
endmodule

bind first_fit_aligned_allocator ffa_props u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .o_rsp(o_rsp), .o_cfg_ready(o_cfg_ready)
);

@@ verif/ffa_checker.sv @@
// Checker: watches request, result and pool-write channels of the allocator and checks results.
module ffa_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  ffa_pkg::t_req  i_req,
    input  logic           i_done,
    input  ffa_pkg::t_rsp  i_rsp,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_ready,
    input  logic [31:0]    i_cfg_data,
    output int             o_errors,
    output int             o_pending
);
    import ffa_pkg::*;

    logic [31:0] chunk_at  [MaxChunks];
    logic [31:0] chunk_len [MaxChunks];
    logic        chunk_used[MaxChunks];
    int          live;
    t_rsp        rsp_queue[$];

    function automatic void table_reset(input logic [31:0] pool);
        for (int k = 0; k < MaxChunks; k++) begin
            chunk_at[k] = '0;
            chunk_len[k] = '0;
            chunk_used[k] = 1'b0;
        end
        chunk_len[0] = pool;
        live = 1;
    endfunction

    function automatic void slot_open(input int pos, input logic [31:0] st,
                                      input logic [31:0] ln, input logic bz);
        for (int k = live; k > pos; k--) begin
            chunk_at[k] = chunk_at[k-1];
            chunk_len[k] = chunk_len[k-1];
            chunk_used[k] = chunk_used[k-1];
        end
        chunk_at[pos] = st;
        chunk_len[pos] = ln;
        chunk_used[pos] = bz;
        live++;
    endfunction

    function automatic void slot_close(input int pos);
        for (int k = pos; k + 1 < live; k++) begin
            chunk_at[k] = chunk_at[k+1];
            chunk_len[k] = chunk_len[k+1];
            chunk_used[k] = chunk_used[k+1];
        end
        live--;
        chunk_at[live] = '0;
        chunk_len[live] = '0;
        chunk_used[live] = 1'b0;
    endfunction

    function automatic t_rsp allocate_or_free(input t_req rq);
        t_rsp r;
        logic [63:0] amask, pad, rest, st, ln, sz;
        int need;
        bit lft, rgt;
        r = '0;
        r.status = ST_NO_FIT;
        if (rq.req_type == REQ_ALLOC) begin
            amask = (64'd1 << rq.align_log2) - 64'd1;
            sz = {32'd0, rq.alloc_size};
            if (sz != 0) begin
                for (int i = 0; i < live; i++) begin
                    if (chunk_used[i]) continue;
                    st = {32'd0, chunk_at[i]};
                    ln = {32'd0, chunk_len[i]};
                    pad = (64'd0 - st) & amask;
                    if (pad > ln || sz > ln - pad) continue;
                    rest = ln - pad - sz;
                    need = (pad != 0) + (rest != 0);
                    if (live + need > MaxChunks) begin
                        r.status = ST_FULL;
                        break;
                    end
                    if (pad == 0) begin
                        chunk_used[i] = 1'b1;
                        chunk_len[i] = sz[31:0];
                        if (rest != 0) slot_open(i + 1, st[31:0] + sz[31:0], rest[31:0], 1'b0);
                    end else begin
                        chunk_len[i] = pad[31:0];
                        slot_open(i + 1, st[31:0] + pad[31:0], sz[31:0], 1'b1);
                        if (rest != 0)
                            slot_open(i + 2, st[31:0] + pad[31:0] + sz[31:0], rest[31:0], 1'b0);
                    end
                    r.status = ST_OK;
                    r.result_offset = st[31:0] + pad[31:0];
                    r.result_size = sz[31:0];
                    break;
                end
            end
        end else begin
            r.status = ST_NOT_FND;
            for (int i = 0; i < live; i++) begin
                if (chunk_used[i] && chunk_at[i] == rq.free_offset) begin
                    lft = i > 0 && !chunk_used[i-1];
                    rgt = i + 1 < live && !chunk_used[i+1];
                    r.status = ST_OK;
                    r.result_offset = rq.free_offset;
                    r.result_size = chunk_len[i];
                    chunk_used[i] = 1'b0;
                    if (rgt) begin
                        chunk_len[i] = chunk_len[i] + chunk_len[i+1];
                        slot_close(i + 1);
                    end
                    if (lft) begin
                        chunk_len[i-1] = chunk_len[i-1] + chunk_len[i];
                        slot_close(i);
                    end
                    break;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            table_reset(PoolReset);
            rsp_queue.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_done) begin
                if (rsp_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_rsp);
                    o_errors <= o_errors + 1;
                end else begin
                    want = rsp_queue.pop_front();
                    if (want.status !== i_rsp.status ||
                        want.result_offset !== i_rsp.result_offset ||
                        want.result_size !== i_rsp.result_size) begin
                        $display("%0t: mismatch expected st=%0d off=%h sz=%h got st=%0d off=%h sz=%h",
                                 $time, want.status, want.result_offset, want.result_size,
                                 i_rsp.status, i_rsp.result_offset, i_rsp.result_size);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_start && !i_busy) rsp_queue = {rsp_queue, allocate_or_free(i_req)};
            if (i_cfg_valid && i_cfg_ready) table_reset(i_cfg_data);
            o_pending <= rsp_queue.size();
        end
    end
endmodule

@@ verif/testbench.sv @@
// Testbench top: drives requests and pool writes into the allocator and gives the verdict.
module testbench;
    import ffa_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    t_req        req;
    logic        done;
    t_rsp        rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    int          errors;
    int          pending;
    logic        last_rt;
    logic [31:0] offsets[$];
    logic [31:0] pools[6] = '{32'd1, 32'hFFFF_FFFF, 32'd4096, 32'd0, 32'd300, 32'd65536};

    first_fit_aligned_allocator u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy), .i_req(req),
        .o_done(done), .o_rsp(rsp), .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_data)
    );

    ffa_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy), .i_req(req),
        .i_done(done), .i_rsp(rsp), .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_data), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk) if (start && !busy) last_rt <= req.req_type;

    // remember granted offsets so frees mostly hit
    always @(posedge clk) begin
        if (rst_n && done && last_rt == REQ_ALLOC && rsp.status == ST_OK &&
            rsp.result_size != 0 &&
            !(offsets.size() > 0 && offsets[$] == rsp.result_offset))
            offsets = {offsets, rsp.result_offset};
    end

    task automatic send(input logic rt, input logic [31:0] sz, input logic [4:0] al,
                        input logic [31:0] fo);
        start <= 1'b1;
        req <= '{req_type: rt, alloc_size: sz, align_log2: al, free_offset: fo};
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending != 0 || busy) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_pool(input logic [31:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        offsets.delete();
        @(posedge clk);
    endtask

    task automatic random_req(input logic [31:0] pool);
        int pick;
        logic [31:0] sz;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            sz = (pick < 5) ? $urandom : $urandom_range(1, (pool > 2000 || pool == 0) ? 2000 : pool);
            if (pick == 6) sz = 0;
            send(REQ_ALLOC, sz, (pick < 10) ? 5'($urandom) : 5'($urandom_range(0, 6)), $urandom);
        end else if (pick < 90 && offsets.size() > 0) begin
            int idx;
            idx = $urandom_range(0, offsets.size() - 1);
            send(REQ_FREE, $urandom, 5'($urandom), offsets[idx]);
            offsets.delete(idx);
        end else begin
            send(REQ_FREE, $urandom, 5'($urandom),
                 (pick < 95) ? $urandom : $urandom_range(0, 4096));
        end
    endtask

    initial begin
        int sent;
        int burst;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fields at extremes, misses, alignment, merge both sides
        send(REQ_ALLOC, 32'd0, 5'd0, 32'd0);
        send(REQ_ALLOC, 32'hFFFF_FFFF, 5'd0, 32'd0);
        send(REQ_ALLOC, 32'd100, 5'd0, 32'd0);
        send(REQ_ALLOC, 32'd100, 5'd8, 32'hFFFF_FFFF);
        send(REQ_ALLOC, 32'd1, 5'd31, 32'd0);
        send(REQ_ALLOC, 32'd10, 5'd4, 32'd0);
        send(REQ_FREE, 32'hFFFF_FFFF, 5'd31, 32'd7);
        send(REQ_FREE, 32'd0, 5'd0, 32'd100);
        send(REQ_FREE, 32'd0, 5'd0, 32'd256);
        send(REQ_FREE, 32'd0, 5'd0, 32'd0);
        send(REQ_FREE, 32'd0, 5'd0, 32'd0);
        send(REQ_ALLOC, 32'd65536, 5'd16, 32'd0);
        write_pool(32'd4096);
        // fill the table with fragments to reach table full
        for (int k = 0; k < 40; k++) send(REQ_ALLOC, 32'd1, 5'd1, 32'd0);
        for (int p = 0; p < 6; p++) begin
            write_pool(pools[p]);
            send(REQ_ALLOC, 32'd1, 5'd0, 32'd0);
            send(REQ_ALLOC, 32'hFFFF_FFFF, 5'd0, 32'd0);
        end
        offsets.delete();

        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            write_pool(pools[(ph + 2) % 6] == 0 ? 32'd2048 : pools[(ph + 2) % 6]);
            while (sent < (ph + 1) * 225) begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst; b++) begin
                    random_req(cfg_data);
                    sent++;
                end
                if ($urandom_range(0, 9) == 0) drain();
                else repeat ($urandom_range(0, 8)) @(posedge clk);
            end
        end
        drain();
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/ffa_pkg.sv
rtl/first_fit_aligned_allocator.sv
rtl/ffa_checker.sv
verif/ffa_checker.sv
verif/testbench.sv
